### design/smb_pkg.sv
package smb_pkg;

   localparam logic signed [15:0] DB_MIN = -16'sd32768;
   localparam logic signed [15:0] DB_MAX = 16'sd32767;

   // dB per octave in Q16: 20*log10(2) for peak, 10*log10(2) for mean square
   localparam logic [18:0] K_PEAK  = 19'd394566;
   localparam logic [18:0] K_POWER = 19'd197283;

   // log2 of full scale
   localparam logic signed [5:0] FS_PEAK  = 6'sd20;
   localparam logic signed [5:0] FS_POWER = 6'sd24;

   localparam int NORM_STEPS = 5;
   localparam int SQR_STEPS  = 16;

   typedef enum logic [7:0] {
      REG_FLOOR_DB        = 8'd0,
      REG_PEAK_DECAY_STEP = 8'd1,
      REG_RMS_COEFF       = 8'd2,
      REG_HOLD_FRAMES     = 8'd3,
      REG_VISIBLE_STEP    = 8'd4
   } reg_index_type;

   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic signed [15:0] floor_db;
      logic [11:0]        peak_decay_step;
      logic [15:0]        rms_coeff;
      logic [7:0]         hold_frames;
      logic [11:0]        visible_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      floor_db:        -16'sd15360,
      peak_decay_step: 12'd171,
      rms_coeff:       16'd7864,
      hold_frames:     8'd45,
      visible_step:    12'd64
   };

   // sequencer strobes shared by all lanes
   typedef struct packed {
      logic       load;
      logic       norm;
      logic       sqr;
      logic       scale;
      logic       finish;
      logic       upd1;
      logic       upd2;
      logic       snap;
      logic [2:0] norm_step;
   } ctl_type;

   typedef struct packed {
      logic signed [15:0] peak_db_left;
      logic signed [15:0] rms_db_left;
      logic signed [15:0] hold_db_left;
      logic signed [15:0] peak_db_right;
      logic signed [15:0] rms_db_right;
      logic signed [15:0] hold_db_right;
      logic               clip_flag;
      logic               redraw;
   } rsp_data_type;

endpackage

### design/smb_ifs.sv
interface smb_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [23:0] peak_left;
   logic [23:0] peak_right;
   logic [31:0] power_left;
   logic [31:0] power_right;
   logic        clip_in;

   modport source (output valid, req_type, peak_left, peak_right, power_left, power_right,
                   clip_in, input ready);
   modport sink (input valid, req_type, peak_left, peak_right, power_left, power_right,
                 clip_in, output ready);
endinterface

interface smb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] peak_db_left;
   logic signed [15:0] rms_db_left;
   logic signed [15:0] hold_db_left;
   logic signed [15:0] peak_db_right;
   logic signed [15:0] rms_db_right;
   logic signed [15:0] hold_db_right;
   logic               clip_flag;
   logic               redraw;

   modport source (output valid, peak_db_left, rms_db_left, hold_db_left, peak_db_right,
                   rms_db_right, hold_db_right, clip_flag, redraw, input ready);
   modport sink (input valid, peak_db_left, rms_db_left, hold_db_left, peak_db_right,
                 rms_db_right, hold_db_right, clip_flag, redraw, output ready);
endinterface

interface smb_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/smb_db_conv.sv
module smb_db_conv
   import smb_pkg::*;
(
   input  logic               clock,
   input  ctl_type            ctl,
   input  logic               power_mode,
   input  logic [31:0]        level,
   input  logic signed [15:0] floor_db,
   output logic signed [15:0] db
);

   logic [31:0]        mant_ff, mant_in;
   logic [4:0]         expo_ff, expo_in;
   logic [15:0]        frac_ff, frac_in;
   logic               zero_ff, zero_in;
   logic signed [41:0] prod_ff, prod_in;
   logic signed [15:0] db_ff, db_in;

   logic [4:0]         norm_amt;
   logic               hi_zero;
   logic [63:0]        square;
   logic [32:0]        sq_top;
   logic signed [5:0]  octave;
   logic signed [21:0] log2_q16;
   logic signed [19:0] k_db;
   logic signed [41:0] rnd_sum;
   logic signed [17:0] db_wide;
   logic signed [15:0] db_sat;

   // binary normalize: shift by 16, 8, 4, 2, 1 while the top bits are clear
   assign norm_amt = 5'(5'd16 >> ctl.norm_step);
   assign hi_zero  = (mant_ff >> (6'd32 - {1'b0, norm_amt})) == 32'd0;

   assign square = 64'(mant_ff) * 64'(mant_ff);
   assign sq_top = square[63:31];

   assign octave   = $signed({1'b0, expo_ff}) - (power_mode ? FS_POWER : FS_PEAK);
   assign log2_q16 = {octave, frac_ff};
   assign k_db     = power_mode ? $signed({1'b0, K_POWER}) : $signed({1'b0, K_PEAK});
   assign prod_in  = log2_q16 * k_db;

   assign rnd_sum = prod_ff + 42'sd8388608;
   assign db_wide = rnd_sum[41:24];

   always_comb begin
      if (db_wide > 18'sd32767) begin
         db_sat = DB_MAX;
      end else if (db_wide < -18'sd32768) begin
         db_sat = DB_MIN;
      end else begin
         db_sat = db_wide[15:0];
      end
      if (zero_ff || (db_sat <= floor_db)) begin
         db_in = floor_db;
      end else begin
         db_in = db_sat;
      end
   end

   always_comb begin
      mant_in = mant_ff;
      expo_in = expo_ff;
      frac_in = frac_ff;
      zero_in = zero_ff;
      if (ctl.load) begin
         mant_in = level;
         expo_in = 5'd31;
         frac_in = '0;
         zero_in = (level == 32'd0);
      end else if (ctl.norm && hi_zero) begin
         mant_in = mant_ff << norm_amt;
         expo_in = expo_ff - norm_amt;
      end else if (ctl.sqr) begin
         mant_in = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
         frac_in = {frac_ff[14:0], sq_top[32]};
      end
   end

   always_ff @(posedge clock) begin
      mant_ff <= mant_in;
      expo_ff <= expo_in;
      frac_ff <= frac_in;
      zero_ff <= zero_in;
      if (ctl.scale) begin
         prod_ff <= prod_in;
      end
      if (ctl.finish) begin
         db_ff <= db_in;
      end
   end

   assign db = db_ff;

endmodule

### design/smb_lane.sv
module smb_lane
   import smb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  cfg_type            cfg,
   input  logic [23:0]        peak,
   input  logic [31:0]        power,
   output logic signed [15:0] peak_db,
   output logic signed [15:0] rms_db,
   output logic signed [15:0] hold_db,
   output logic               moved
);

   function automatic logic beyond_step(input logic signed [15:0] a,
                                        input logic signed [15:0] b,
                                        input logic [11:0] step);
      logic signed [16:0] d;
      logic [16:0]        mag;
      d   = $signed({a[15], a}) - $signed({b[15], b});
      mag = (d < 0) ? 17'(-d) : 17'(d);
      return mag > {5'd0, step};
   endfunction

   logic signed [15:0] pdb, rdb;

   logic signed [15:0] peak_ff, peak_in;
   logic signed [15:0] rms_ff, rms_in;
   logic signed [15:0] hold_ff, hold_in;
   logic [7:0]         age_ff, age_in;
   logic signed [15:0] shown_ff [3];
   logic signed [15:0] shown_in [3];
   logic signed [33:0] rms_prod_ff, rms_prod_in;

   logic signed [16:0] decay;
   logic signed [16:0] rms_diff;
   logic signed [33:0] rms_sum;
   logic signed [17:0] rms_step;
   logic signed [18:0] rms_wide;
   logic [7:0]         age_sat;

   smb_db_conv u_peak_conv (
      .clock      (clock),
      .ctl        (ctl),
      .power_mode (1'b0),
      .level      ({8'd0, peak}),
      .floor_db   (cfg.floor_db),
      .db         (pdb)
   );

   smb_db_conv u_power_conv (
      .clock      (clock),
      .ctl        (ctl),
      .power_mode (1'b1),
      .level      (power),
      .floor_db   (cfg.floor_db),
      .db         (rdb)
   );

   assign decay       = $signed({peak_ff[15], peak_ff}) - $signed({5'd0, cfg.peak_decay_step});
   assign rms_diff    = $signed({rdb[15], rdb}) - $signed({rms_ff[15], rms_ff});
   assign rms_prod_in = rms_diff * $signed({1'b0, cfg.rms_coeff});
   assign rms_sum     = rms_prod_ff + 34'sd32768;
   assign rms_step    = rms_sum[33:16];
   assign rms_wide    = $signed({{3{rms_ff[15]}}, rms_ff}) + $signed({rms_step[17], rms_step});
   assign age_sat     = (age_ff == 8'hFF) ? 8'hFF : age_ff + 8'd1;

   always_comb begin
      peak_in = peak_ff;
      rms_in  = rms_ff;
      hold_in = hold_ff;
      age_in  = age_ff;
      for (int i = 0; i < 3; i++) begin
         shown_in[i] = shown_ff[i];
      end

      if (ctl.upd1) begin
         if (pdb > peak_ff) begin
            peak_in = pdb;
         end else if (decay > $signed({pdb[15], pdb})) begin
            peak_in = decay[15:0];
         end else begin
            peak_in = pdb;
         end
      end

      if (ctl.upd2) begin
         if (rms_wide > 19'sd32767) begin
            rms_in = DB_MAX;
         end else if (rms_wide < -19'sd32768) begin
            rms_in = DB_MIN;
         end else begin
            rms_in = rms_wide[15:0];
         end
         if (peak_ff >= hold_ff) begin
            hold_in = peak_ff;
            age_in  = '0;
         end else begin
            age_in = age_sat;
            if (age_sat > cfg.hold_frames) begin
               hold_in = peak_ff;
            end
         end
      end

      if (ctl.snap) begin
         shown_in[0] = peak_ff;
         shown_in[1] = rms_ff;
         shown_in[2] = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= DB_MIN;
         rms_ff  <= DB_MIN;
         hold_ff <= DB_MIN;
         age_ff  <= '0;
         for (int i = 0; i < 3; i++) begin
            shown_ff[i] <= DB_MIN;
         end
      end else begin
         peak_ff <= peak_in;
         rms_ff  <= rms_in;
         hold_ff <= hold_in;
         age_ff  <= age_in;
         for (int i = 0; i < 3; i++) begin
            shown_ff[i] <= shown_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.upd1) begin
         rms_prod_ff <= rms_prod_in;
      end
   end

   assign moved = beyond_step(peak_ff, shown_ff[0], cfg.visible_step)
               || beyond_step(rms_ff, shown_ff[1], cfg.visible_step)
               || beyond_step(hold_ff, shown_ff[2], cfg.visible_step);

   assign peak_db = peak_ff;
   assign rms_db  = rms_ff;
   assign hold_db = hold_ff;

endmodule

### design/stereo_meter_ballistics_core.sv
// channel   dir  handshake      carries
// req_chan  in   valid / ready  req_type, peak_left/right, power_left/right, clip_in
// rsp_chan  out  valid / ready  peak/rms/hold dB left and right, clip_flag, redraw
// csr_chan  in   valid / ready  index, data (register write, ready whenever out of reset)
//
// a frame tick runs through 5 normalize steps, 16 squaring steps of the log2 unit
// in each lane, scale, round, 2 update steps and merge
// a clear request skips to the merge step; one request is in flight at a time
// a result waits in the output register; the merge step holds while it is full
// reset is synchronous, active high, and brings levels to the most negative code
module stereo_meter_ballistics_core
   import smb_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input logic     clock,
   input logic     reset,
   smb_req_if.sink   req_chan,
   smb_rsp_if.source rsp_chan,
   smb_csr_if.sink   csr_chan
);

   // one-hot sequencer
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_NORM   = 8'b0000_0010,
      S_SQR    = 8'b0000_0100,
      S_SCALE  = 8'b0000_1000,
      S_FINISH = 8'b0001_0000,
      S_UPD1   = 8'b0010_0000,
      S_UPD2   = 8'b0100_0000,
      S_MERGE  = 8'b1000_0000
   } state_type;

   state_type    state_ff, state_in;
   logic [3:0]   step_ff, step_in;
   cfg_type      cfg_ff, cfg_in;
   logic         clear_ff;
   logic         clip_in_ff;
   logic         clip_ff, clip_in;
   logic         shown_clip_ff, shown_clip_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   ctl_type      ctl;
   logic         req_accept;
   logic         merge_fire;
   logic         clip_next;
   logic         redraw_now;

   logic signed [15:0] lane_peak [CHANNELS];
   logic signed [15:0] lane_rms  [CHANNELS];
   logic signed [15:0] lane_hold [CHANNELS];
   logic [CHANNELS-1:0] lane_moved;
   logic signed [15:0] right_peak, right_rms, right_hold;

   // request side: only taken while the sequencer is free and out of reset
   assign req_chan.ready = state_ff[0] && !reset;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // register writes are taken whenever out of reset
   assign csr_chan.ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_FLOOR_DB:        cfg_in.floor_db        = csr_chan.data;
            REG_PEAK_DECAY_STEP: cfg_in.peak_decay_step = csr_chan.data[11:0];
            REG_RMS_COEFF:       cfg_in.rms_coeff       = csr_chan.data;
            REG_HOLD_FRAMES:     cfg_in.hold_frames     = csr_chan.data[7:0];
            REG_VISIBLE_STEP:    cfg_in.visible_step    = csr_chan.data[11:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // merge fires once the output register is free or being emptied
   assign merge_fire = (state_ff == S_MERGE) && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_chan.req_type == REQ_CLEAR) ? S_MERGE : S_NORM;
               step_in  = '0;
            end
         end
         S_NORM: begin
            if (step_ff == 4'(NORM_STEPS - 1)) begin
               state_in = S_SQR;
               step_in  = '0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_SQR: begin
            if (step_ff == 4'(SQR_STEPS - 1)) begin
               state_in = S_SCALE;
               step_in  = '0;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_SCALE:  state_in = S_FINISH;
         S_FINISH: state_in = S_UPD1;
         S_UPD1:   state_in = S_UPD2;
         S_UPD2:   state_in = S_MERGE;
         S_MERGE: begin
            if (merge_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // strobes to the lanes
   assign ctl.load      = req_accept;
   assign ctl.norm      = state_ff[1];
   assign ctl.sqr       = state_ff[2];
   assign ctl.scale     = state_ff[3];
   assign ctl.finish    = state_ff[4];
   assign ctl.upd1      = state_ff[5];
   assign ctl.upd2      = state_ff[6];
   assign ctl.snap      = merge_fire && redraw_now;
   assign ctl.norm_step = step_ff[2:0];

   // one lane per channel; channels past the right one see silence
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      logic [23:0] peak_sel;
      logic [31:0] power_sel;

      if (c == 0) begin : g_left
         assign peak_sel  = req_chan.peak_left;
         assign power_sel = req_chan.power_left;
      end else if (c == 1) begin : g_right
         assign peak_sel  = req_chan.peak_right;
         assign power_sel = req_chan.power_right;
      end else begin : g_quiet
         assign peak_sel  = '0;
         assign power_sel = '0;
      end

      smb_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .cfg     (cfg_ff),
         .peak    (peak_sel),
         .power   (power_sel),
         .peak_db (lane_peak[c]),
         .rms_db  (lane_rms[c]),
         .hold_db (lane_hold[c]),
         .moved   (lane_moved[c])
      );
   end

   if (CHANNELS > 1) begin : g_stereo
      assign right_peak = lane_peak[1];
      assign right_rms  = lane_rms[1];
      assign right_hold = lane_hold[1];
   end else begin : g_mono
      assign right_peak = '0;
      assign right_rms  = '0;
      assign right_hold = '0;
   end

   // merge: sticky clip, redraw decision over all lanes
   assign clip_next  = (clear_ff == REQ_CLEAR) ? 1'b0 : (clip_ff || clip_in_ff);
   assign redraw_now = (clear_ff == REQ_CLEAR) || (clip_next != shown_clip_ff)
                    || (|lane_moved);

   always_comb begin
      clip_in       = clip_ff;
      shown_clip_in = shown_clip_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (merge_fire) begin
         clip_in = clip_next;
         if (redraw_now) begin
            shown_clip_in = clip_next;
         end
         rsp_valid_in              = 1'b1;
         rsp_data_in.peak_db_left  = lane_peak[0];
         rsp_data_in.rms_db_left   = lane_rms[0];
         rsp_data_in.hold_db_left  = lane_hold[0];
         rsp_data_in.peak_db_right = right_peak;
         rsp_data_in.rms_db_right  = right_rms;
         rsp_data_in.hold_db_right = right_hold;
         rsp_data_in.clip_flag     = clip_next;
         rsp_data_in.redraw        = redraw_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         cfg_ff        <= CFG_RESET;
         clip_ff       <= 1'b0;
         shown_clip_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cfg_ff        <= cfg_in;
         clip_ff       <= clip_in;
         shown_clip_ff <= shown_clip_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request fields held for the merge step, result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         clear_ff   <= req_chan.req_type;
         clip_in_ff <= req_chan.clip_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.peak_db_left  = rsp_data_ff.peak_db_left;
   assign rsp_chan.rms_db_left   = rsp_data_ff.rms_db_left;
   assign rsp_chan.hold_db_left  = rsp_data_ff.hold_db_left;
   assign rsp_chan.peak_db_right = rsp_data_ff.peak_db_right;
   assign rsp_chan.rms_db_right  = rsp_data_ff.rms_db_right;
   assign rsp_chan.hold_db_right = rsp_data_ff.hold_db_right;
   assign rsp_chan.clip_flag     = rsp_data_ff.clip_flag;
   assign rsp_chan.redraw        = rsp_data_ff.redraw;

`ifndef SYNTH
   // a result never shows up in the cycle right after a request is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !$rose(rsp_valid_ff))
      else $error("result raised right after request acceptance");

   // a clear request always yields a redraw with the clip indicator down
   a_clear_redraw: assert property (@(posedge clock) disable iff (reset)
      (merge_fire && (clear_ff == REQ_CLEAR)) |=> (rsp_valid_ff && rsp_data_ff.redraw
                                                   && !rsp_data_ff.clip_flag))
      else $error("clear request did not redraw with clip cleared");

   // the sticky clip only comes up from a tick that reported a clip
   a_clip_source: assert property (@(posedge clock) disable iff (reset)
      $rose(clip_ff) |-> $past(merge_fire && (clear_ff == REQ_TICK) && clip_in_ff))
      else $error("clip indicator set without a clipped tick");
`endif

endmodule

### test/stereo_meter_ballistics_core_test.sv
`timescale 1ns / 1ps

module stereo_meter_ballistics_core_test;
   import smb_pkg::*;

   // run limits, generous against the slowest legal run
   localparam int         CYCLE_LIMIT       = 500000;
   localparam int         LONG_STALL_CYCLES = 300;
   localparam int         TAIL_CYCLES       = 40;
   localparam int         SETTLE_CYCLES     = 4;
   localparam int         REPORT_LIMIT      = 10;
   // an index no register answers to
   localparam logic [7:0] REG_UNMAPPED      = 8'hA5;

   // how the result side takes readings
   typedef enum logic [1:0] {
      PACE_FREE,
      PACE_RANDOM,
      PACE_COMB
   } sink_pace_type;

   // one request as the sender sees it
   typedef struct {
      req_kind_type kind;
      logic [23:0]  peak_left;
      logic [23:0]  peak_right;
      logic [31:0]  power_left;
      logic [31:0]  power_right;
      logic         clip_in;
   } frame_type;

   logic clock;
   logic reset;

   smb_req_if req_chan();
   smb_rsp_if rsp_chan();
   smb_csr_if csr_chan();

   stereo_meter_ballistics_core #(.CHANNELS(2)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // requests waiting to be offered, and readings the meter should produce
   frame_type    pending_frames[$];
   rsp_data_type predicted_readings[$];

   // meter settings as last written
   logic signed [15:0] cfg_floor;
   logic [11:0]        cfg_decay;
   logic [15:0]        cfg_coeff;
   logic [7:0]         cfg_hold;
   logic [11:0]        cfg_visible;

   // ballistics state per channel, 0 = left, 1 = right
   logic signed [15:0] peak_lvl[2];
   logic signed [15:0] rms_lvl[2];
   logic signed [15:0] hold_lvl[2];
   logic [7:0]         hold_age[2];
   logic               clip_sticky;
   logic signed [15:0] shown_lvl[2][3];
   logic               shown_clip;

   // handshake bookkeeping between the clocked processes
   logic          req_taken;
   int unsigned   burst_left;
   int unsigned   gap_left;
   sink_pace_type sink_pace;
   int unsigned   sink_tick;
   int unsigned   stall_left;
   int unsigned   stalls_asked;
   int unsigned   stalls_served;

   // run statistics
   int unsigned cycles;
   int unsigned mismatches;
   int unsigned frames_sent;
   int unsigned clears_sent;
   int unsigned clipped_sent;
   int unsigned readings_checked;
   int unsigned settings_used;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor of the meter
   // ---------------------------------------------------------------

   // floor((p + 2^(s-1)) / 2^s), arithmetic shift keeps the floor for negatives
   function automatic int round_q(longint p, int s);
      return int'((p + (longint'(1) <<< (s - 1))) >>> s);
   endfunction

   function automatic int clamp_db(int v);
      if (v < int'(DB_MIN)) return int'(DB_MIN);
      if (v > int'(DB_MAX)) return int'(DB_MAX);
      return v;
   endfunction

   // linear value to Q8.8 dB: integer log2 from the msb, 16 fraction bits by squaring
   function automatic int lin_to_db(logic [31:0] v, int fs, longint k);
      int          e;
      int          frac;
      int          i;
      int          db;
      logic [63:0] m;
      if (v == 32'd0) return int'(cfg_floor);
      e = 31;
      while (!v[e]) e--;
      m = 64'(v) << (31 - e);
      frac = 0;
      for (i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      db = clamp_db(round_q(longint'((e - fs) * 65536 + frac) * k, 24));
      return (db > int'(cfg_floor)) ? db : int'(cfg_floor);
   endfunction

   function automatic logic level_moved(logic signed [15:0] now, logic signed [15:0] shown);
      int d;
      d = int'(now) - int'(shown);
      if (d < 0) d = -d;
      return d > int'(cfg_visible);
   endfunction

   function automatic void take_snapshot();
      int ch;
      for (ch = 0; ch < 2; ch++) begin
         shown_lvl[ch][0] = peak_lvl[ch];
         shown_lvl[ch][1] = rms_lvl[ch];
         shown_lvl[ch][2] = hold_lvl[ch];
      end
      shown_clip = clip_sticky;
   endfunction

   function automatic void meter_reset();
      int ch;
      cfg_floor   = CFG_RESET.floor_db;
      cfg_decay   = CFG_RESET.peak_decay_step;
      cfg_coeff   = CFG_RESET.rms_coeff;
      cfg_hold    = CFG_RESET.hold_frames;
      cfg_visible = CFG_RESET.visible_step;
      for (ch = 0; ch < 2; ch++) begin
         peak_lvl[ch] = DB_MIN;
         rms_lvl[ch]  = DB_MIN;
         hold_lvl[ch] = DB_MIN;
         hold_age[ch] = 8'd0;
      end
      clip_sticky = 1'b0;
      take_snapshot();
   endfunction

   // advance the meter by one request and return the reading it gives
   function automatic rsp_data_type meter_advance(frame_type f);
      rsp_data_type r;
      int           ch;
      int           pdb;
      int           rdb;
      int           dec;
      logic [23:0]  pk;
      logic [31:0]  pw;
      logic         move;
      if (f.kind == REQ_CLEAR) begin
         // clear request: drop the clip, mark everything as shown
         clip_sticky = 1'b0;
         take_snapshot();
         move = 1'b1;
      end else begin
         for (ch = 0; ch < 2; ch++) begin
            pk = (ch == 0) ? f.peak_left : f.peak_right;
            pw = (ch == 0) ? f.power_left : f.power_right;
            pdb = lin_to_db({8'd0, pk}, int'(FS_PEAK), longint'(K_PEAK));
            rdb = lin_to_db(pw, int'(FS_POWER), longint'(K_POWER));
            // peak attacks at once, otherwise falls by the decay step
            if (pdb > int'(peak_lvl[ch])) begin
               peak_lvl[ch] = 16'(pdb);
            end else begin
               dec = int'(peak_lvl[ch]) - int'(cfg_decay);
               peak_lvl[ch] = 16'((dec > pdb) ? dec : pdb);
            end
            // one-pole smoothing in dB
            rms_lvl[ch] = 16'(clamp_db(int'(rms_lvl[ch]) + round_q(
               longint'(cfg_coeff) * longint'(rdb - int'(rms_lvl[ch])), 16)));
            // hold marker with saturating age
            if (peak_lvl[ch] >= hold_lvl[ch]) begin
               hold_lvl[ch] = peak_lvl[ch];
               hold_age[ch] = 8'd0;
            end else begin
               if (hold_age[ch] != 8'hFF) hold_age[ch] = hold_age[ch] + 8'd1;
               if (hold_age[ch] > cfg_hold) hold_lvl[ch] = peak_lvl[ch];
            end
         end
         if (f.clip_in) clip_sticky = 1'b1;
         move = (clip_sticky != shown_clip);
         for (ch = 0; ch < 2; ch++) begin
            if (level_moved(peak_lvl[ch], shown_lvl[ch][0]) ||
                level_moved(rms_lvl[ch], shown_lvl[ch][1]) ||
                level_moved(hold_lvl[ch], shown_lvl[ch][2]))
               move = 1'b1;
         end
         if (move) take_snapshot();
      end
      r.peak_db_left  = peak_lvl[0];
      r.rms_db_left   = rms_lvl[0];
      r.hold_db_left  = hold_lvl[0];
      r.peak_db_right = peak_lvl[1];
      r.rms_db_right  = rms_lvl[1];
      r.hold_db_right = hold_lvl[1];
      r.clip_flag     = clip_sticky;
      r.redraw        = move;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // request side: driver at the falling edge, monitor at the rising edge
   // ---------------------------------------------------------------

   // sender works in bursts; valid is written once per falling edge
   always @(negedge clock) begin
      logic      offer;
      frame_type nxt;
      offer = req_chan.valid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         // request taken at the last rising edge
         if (offer && req_taken) offer = 1'b0;
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_frames.size() > 0) begin
               nxt = pending_frames.pop_front();
               req_chan.req_type    <= nxt.kind;
               req_chan.peak_left   <= nxt.peak_left;
               req_chan.peak_right  <= nxt.peak_right;
               req_chan.power_left  <= nxt.power_left;
               req_chan.power_right <= nxt.power_right;
               req_chan.clip_in     <= nxt.clip_in;
               offer = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // end of burst: pick the next burst and the gap before it
                  burst_left = $urandom_range(0, 23);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
      end
      req_chan.valid <= offer;
   end

   // every accepted request advances the predictor
   always @(posedge clock) begin
      frame_type seen;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         seen.kind        = req_kind_type'(req_chan.req_type);
         seen.peak_left   = req_chan.peak_left;
         seen.peak_right  = req_chan.peak_right;
         seen.power_left  = req_chan.power_left;
         seen.power_right = req_chan.power_right;
         seen.clip_in     = req_chan.clip_in;
         predicted_readings.push_back(meter_advance(seen));
         frames_sent++;
         if (seen.kind == REQ_CLEAR) clears_sent++;
         else if (seen.clip_in) clipped_sent++;
      end
   end

   // ---------------------------------------------------------------
   // result side: ready pattern at the falling edge, checks at the rising edge
   // ---------------------------------------------------------------

   always @(negedge clock) begin
      logic take;
      take = 1'b0;
      sink_tick++;
      if (reset) begin
         take = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (stalls_served != stalls_asked) begin
         // long hold-off so the meter fills up and backs off its input
         stalls_served++;
         stall_left = LONG_STALL_CYCLES;
      end else begin
         case (sink_pace)
            PACE_FREE:   take = 1'b1;
            PACE_RANDOM: take = ($urandom_range(0, 99) < 65);
            default:     take = ((sink_tick % 9) >= 3);
         endcase
      end
      rsp_chan.ready <= take;
   end

   task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("reading %0d: %s expected %0d (0x%04h) got %0d (0x%04h)",
                     readings_checked, what, $signed(want), want, $signed(got), got);
      end
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_readings.size() == 0) begin
            // reading with no request behind it
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("reading with no pending request at cycle %0d", cycles);
         end else begin
            want = predicted_readings.pop_front();
            check_field("peak_db_left", want.peak_db_left, rsp_chan.peak_db_left);
            check_field("rms_db_left", want.rms_db_left, rsp_chan.rms_db_left);
            check_field("hold_db_left", want.hold_db_left, rsp_chan.hold_db_left);
            check_field("peak_db_right", want.peak_db_right, rsp_chan.peak_db_right);
            check_field("rms_db_right", want.rms_db_right, rsp_chan.rms_db_right);
            check_field("hold_db_right", want.hold_db_right, rsp_chan.hold_db_right);
            check_field("clip_flag", {15'd0, want.clip_flag}, {15'd0, rsp_chan.clip_flag});
            check_field("redraw", {15'd0, want.redraw}, {15'd0, rsp_chan.redraw});
            readings_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("no progress, run stopped after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // register writes and stimulus
   // ---------------------------------------------------------------

   // register write, only called while the meter is idle
   task automatic csr_write(logic [7:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         REG_FLOOR_DB:        cfg_floor = val;
         REG_PEAK_DECAY_STEP: cfg_decay = val[11:0];
         REG_RMS_COEFF:       cfg_coeff = val;
         REG_HOLD_FRAMES:     cfg_hold = val[7:0];
         REG_VISIBLE_STEP:    cfg_visible = val[11:0];
         default:             ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // all five registers; unused upper bits of the narrow ones carry junk
   task automatic set_meter(int floor_db, int decay, int coeff, int hold, int visible);
      csr_write(REG_FLOOR_DB, 16'(floor_db));
      csr_write(REG_PEAK_DECAY_STEP, {4'($urandom), 12'(decay)});
      csr_write(REG_RMS_COEFF, 16'(coeff));
      csr_write(REG_HOLD_FRAMES, {8'($urandom), 8'(hold)});
      csr_write(REG_VISIBLE_STEP, {4'($urandom), 12'(visible)});
      settings_used++;
   endtask

   task automatic set_meter_random(int hold);
      set_meter(-int'($urandom_range(0, 32768)), $urandom_range(0, 2560),
                $urandom_range(0, 65535), hold, $urandom_range(0, 2560));
   endtask

   task automatic queue_frame(req_kind_type kind, logic [23:0] pl, logic [23:0] pr,
                              logic [31:0] wl, logic [31:0] wr, logic clip);
      frame_type f;
      f.kind        = kind;
      f.peak_left   = pl;
      f.peak_right  = pr;
      f.power_left  = wl;
      f.power_right = wr;
      f.clip_in     = clip;
      pending_frames.push_back(f);
   endtask

   // random magnitude roughly depth octaves below the top of the field
   function automatic logic [23:0] rand_peak(int unsigned depth);
      return 24'($urandom >> (8 + depth));
   endfunction

   function automatic logic [31:0] rand_power(int unsigned depth);
      return $urandom >> depth;
   endfunction

   // program material: a loud hit, then a quiet tail long enough for the peak
   // to fall and the hold marker to expire, with clears and noise mixed in
   task automatic queue_passages(int unsigned count);
      int unsigned made;
      int unsigned hit_l;
      int unsigned hit_r;
      int unsigned quiet;
      int unsigned k;
      int unsigned roll;
      int unsigned dl;
      int unsigned dr;
      made = 0;
      while (made < count) begin
         hit_l = $urandom_range(0, 6);
         hit_r = ($urandom_range(0, 1) == 1) ? hit_l : $urandom_range(0, 8);
         queue_frame(REQ_TICK, rand_peak(hit_l), rand_peak(hit_r),
                     rand_power(2 * hit_l), rand_power(2 * hit_r),
                     $urandom_range(0, 3) == 0);
         made++;
         quiet = $urandom_range(1, 70);
         for (k = 0; k < quiet && made < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               // clear request, level fields carry junk
               queue_frame(REQ_CLEAR, 24'($urandom), 24'($urandom), $urandom, $urandom,
                           1'($urandom));
            end else if (roll < 8) begin
               queue_frame(req_kind_type'($urandom_range(0, 1)), 24'($urandom),
                           24'($urandom), $urandom, $urandom, 1'($urandom));
            end else if (roll < 11) begin
               queue_frame(REQ_TICK, 24'd0, 24'd0, 32'd0, 32'd0, 1'b0);
            end else begin
               dl = hit_l + $urandom_range(1, 14);
               dr = hit_r + $urandom_range(1, 14);
               if (dl > 22) dl = 22;
               if (dr > 22) dr = 22;
               queue_frame(REQ_TICK, rand_peak(dl), rand_peak(dr),
                           rand_power(2 * dl + $urandom_range(0, 3)),
                           rand_power(2 * dr + $urandom_range(0, 3)),
                           $urandom_range(0, 49) == 0);
            end
            made++;
         end
      end
   endtask

   // sender stays quiet until every reading is back
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_frames.size() != 0 || req_chan.valid || predicted_readings.size() != 0);
   endtask

   task automatic run_phase(sink_pace_type pace, int unsigned count);
      @(posedge clock);
      sink_pace = pace;
      queue_passages(count);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      // every input known from time zero
      reset = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_TICK;
      req_chan.peak_left   = 24'd0;
      req_chan.peak_right  = 24'd0;
      req_chan.power_left  = 32'd0;
      req_chan.power_right = 32'd0;
      req_chan.clip_in     = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = REG_FLOOR_DB;
      csr_chan.data        = 16'd0;
      req_taken     = 1'b0;
      burst_left    = 0;
      gap_left      = 0;
      sink_pace     = PACE_FREE;
      sink_tick     = 0;
      stall_left    = 0;
      stalls_asked  = 0;
      stalls_served = 0;
      cycles           = 0;
      mismatches       = 0;
      frames_sent      = 0;
      clears_sent      = 0;
      clipped_sent     = 0;
      readings_checked = 0;
      settings_used    = 1;
      meter_reset();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests at the reset settings
      @(posedge clock);
      sink_pace = PACE_RANDOM;
      // silence gives the floor
      queue_frame(REQ_TICK, 24'd0, 24'd0, 32'd0, 32'd0, 1'b0);
      // exactly full scale is 0 dB
      queue_frame(REQ_TICK, 24'h100000, 24'h100000, 32'h0100_0000, 32'h0100_0000, 1'b0);
      // largest codes, above full scale, with a clip
      queue_frame(REQ_TICK, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      // clear ignores its level fields and clip bit
      queue_frame(REQ_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      // unchanged input levels after the clear
      queue_frame(REQ_TICK, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      // smallest nonzero level lands below the floor
      queue_frame(REQ_TICK, 24'd1, 24'hFFFFFF, 32'd1, 32'hFFFF_FFFF, 1'b0);
      // silence lets the peak fall step by step
      repeat (6) queue_frame(REQ_TICK, 24'd0, 24'd0, 32'd0, 32'd0, 1'b0);
      // clear with nothing clipped
      queue_frame(REQ_CLEAR, 24'd0, 24'd0, 32'd0, 32'd0, 1'b0);
      // just below full scale
      queue_frame(REQ_TICK, 24'h0FFFFF, 24'h0FFFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 1'b0);
      queue_frame(REQ_TICK, 24'h080000, 24'h800000, 32'h0080_0000, 32'h8000_0000, 1'b0);
      queue_frame(REQ_TICK, 24'h800000, 24'h000001, 32'h8000_0000, 32'h0000_0001, 1'b0);
      // clip on silence, then again while already sticky
      queue_frame(REQ_TICK, 24'd0, 24'd0, 32'd0, 32'd0, 1'b1);
      queue_frame(REQ_TICK, 24'd0, 24'd0, 32'd0, 32'd0, 1'b1);
      queue_frame(REQ_CLEAR, 24'h5A5A5A, 24'hA5A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0);
      queue_frame(REQ_TICK, 24'($urandom), 24'($urandom), $urandom, $urandom, 1'b0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // zero decay, hold and visible step, floor at 0 dB, fastest smoothing
      set_meter(0, 0, 65535, 0, 0);
      run_phase(PACE_RANDOM, 130);

      // bottom of the floor, widest steps, frozen rms, hold at 254
      set_meter(int'(DB_MIN), 2560, 0, 254, 2560);
      @(posedge clock);
      sink_pace = PACE_COMB;
      queue_passages(130);
      // hold off the result side while requests keep coming
      stalls_asked++;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      // random settings, plus a write to an index no register answers to
      set_meter_random($urandom_range(0, 254));
      csr_write(REG_UNMAPPED, 16'($urandom));
      run_phase(PACE_RANDOM, 130);

      // reset-like settings with a short hold
      set_meter(-15360, 171, 7864, 3, 64);
      run_phase(PACE_FREE, 150);

      // hold marker that only the peak itself can move
      set_meter_random(255);
      run_phase(PACE_COMB, 130);

      set_meter_random($urandom_range(0, 254));
      run_phase(PACE_RANDOM, 130);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (predicted_readings.size() != 0) begin
         mismatches++;
         $display("%0d readings never arrived", predicted_readings.size());
      end

      $display("%0d requests (%0d clears, %0d clipped frames), %0d readings checked",
               frames_sent, clears_sent, clipped_sent, readings_checked);
      $display("%0d meter settings, %0d mismatches", settings_used, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
